// ===== src/ubb_pkg.sv =====
// ubb_pkg: types and constants shared by the debug bus bridge modules
// no dependencies; imported by ubb_front, ubb_fifo, ubb_back and the top level
`default_nettype none

package ubb_pkg;

  // field widths fixed by the item format
  localparam int unsigned DataW       = 32;
  localparam int unsigned CountW      = 7;
  localparam int unsigned ByteCntW    = 3;
  localparam int unsigned DefAddrW    = 32;
  localparam int unsigned QueueDepth  = 2;

  // protocol constants
  localparam logic [7:0] BaudByte     = 8'h55;
  localparam int unsigned CmdBit      = 7;
  localparam int unsigned WriteBit    = 6;
  localparam logic [5:0] LenMask      = 6'h3F;
  localparam int unsigned AddrStep    = 4;
  localparam logic [ByteCntW-1:0] LastAddrByte = 3'd7;
  localparam logic [ByteCntW-1:0] LastDataByte = 3'd3;
  localparam logic [ByteCntW-1:0] UsedAddrBytes = 3'd4;

  // input item kinds
  typedef enum logic {
    FUNC_HOST_BYTE = 1'b0,
    FUNC_READ_RESP = 1'b1
  } func_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BUS_WRITE = 2'd0,
    KIND_BUS_READ  = 2'd1,
    KIND_HOST_WORD = 2'd2,
    KIND_FMT_ERROR = 2'd3
  } kind_e;

  // packet parser phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef struct packed {
    logic              func;
    logic [7:0]        host_byte;
    logic [DataW-1:0]  read_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DataW-1:0]  bus_address;
    logic [DataW-1:0]  word_data;
    logic              last_of_run;
  } out_item_t;

  // one job from front to back: count results starting at addr
  typedef struct packed {
    kind_e             kind;
    logic [DataW-1:0]  addr;
    logic [DataW-1:0]  data;
    logic              last;
    logic [CountW-1:0] count;
  } job_t;

endpackage

`default_nettype wire

// ===== src/ubb_front.sv =====
// ubb_front: packet parser, accepts input beats and turns them into jobs
// depends on ubb_pkg
`default_nettype none

module ubb_front
  import ubb_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = DefAddrW
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          push_o,
  output job_t          job_o,
  input  wire logic     full_i
);

  logic                  detected_q, detected_d;
  phase_e                phase_q, phase_d;
  logic [ByteCntW-1:0]   byte_cnt_q, byte_cnt_d;
  logic [CountW-1:0]     words_left_q, words_left_d;
  logic                  write_mode_q, write_mode_d;
  logic [ADDR_WIDTH-1:0] cur_addr_q, cur_addr_d;
  logic [DataW-1:0]      word_shift_q, word_shift_d;

  logic                  in_acc;
  logic [7:0]            b;
  logic [DataW-1:0]      byte_shifted;
  logic [DataW-1:0]      addr_merged;
  logic [DataW-1:0]      word_merged;
  logic [CountW-1:0]     words_dec;

  // any beat may produce a job, so take one only with queue room
  assign in_ready_o   = !full_i;
  assign in_acc       = in_valid_i && in_ready_o;
  assign b            = in_item_i.host_byte;
  assign byte_shifted = DataW'(b) << {byte_cnt_q[1:0], 3'b000};
  assign addr_merged  = DataW'(cur_addr_q) | byte_shifted;
  assign word_merged  = word_shift_q | byte_shifted;
  assign words_dec    = (words_left_q != '0) ? words_left_q - CountW'(1) : words_left_q;

  // parser next state and job generation
  always_comb begin
    detected_d   = detected_q;
    phase_d      = phase_q;
    byte_cnt_d   = byte_cnt_q;
    words_left_d = words_left_q;
    write_mode_d = write_mode_q;
    cur_addr_d   = cur_addr_q;
    word_shift_d = word_shift_q;
    push_o       = 1'b0;
    job_o        = '0;
    job_o.count  = CountW'(1);
    job_o.last   = 1'b1;
    if (in_acc) begin
      if (in_item_i.func == FUNC_READ_RESP) begin
        // read data goes straight back to the host
        push_o     = 1'b1;
        job_o.kind = KIND_HOST_WORD;
        job_o.data = in_item_i.read_word;
      end else if (!detected_q) begin
        if (b == BaudByte) begin
          detected_d = 1'b1;
        end
      end else begin
        case (phase_q)
          PH_ADDR: begin
            if (byte_cnt_q < UsedAddrBytes) begin
              cur_addr_d = addr_merged[ADDR_WIDTH-1:0];
            end
            if (byte_cnt_q < LastAddrByte) begin
              byte_cnt_d = byte_cnt_q + ByteCntW'(1);
            end else begin
              byte_cnt_d = '0;
              if (write_mode_q) begin
                word_shift_d = '0;
                phase_d      = PH_DATA;
              end else begin
                // whole read burst as one job
                push_o       = 1'b1;
                job_o.kind   = KIND_BUS_READ;
                job_o.addr   = DataW'(cur_addr_d);
                job_o.count  = words_left_q;
                words_left_d = '0;
                phase_d      = PH_IDLE;
              end
            end
          end
          PH_DATA: begin
            if (byte_cnt_q < LastDataByte) begin
              word_shift_d = word_merged;
              byte_cnt_d   = byte_cnt_q + ByteCntW'(1);
            end else begin
              push_o       = 1'b1;
              job_o.kind   = KIND_BUS_WRITE;
              job_o.addr   = DataW'(cur_addr_q);
              job_o.data   = word_merged;
              job_o.last   = (words_left_q <= CountW'(1));
              cur_addr_d   = cur_addr_q + ADDR_WIDTH'(AddrStep);
              byte_cnt_d   = '0;
              word_shift_d = '0;
              words_left_d = words_dec;
              if (words_dec == '0) begin
                phase_d = PH_IDLE;
              end
            end
          end
          default: begin
            // command byte
            phase_d = PH_IDLE;
            if (!b[CmdBit]) begin
              push_o     = 1'b1;
              job_o.kind = KIND_FMT_ERROR;
            end else begin
              write_mode_d = b[WriteBit];
              words_left_d = CountW'(b[5:0] & LenMask) + CountW'(1);
              byte_cnt_d   = '0;
              cur_addr_d   = '0;
              word_shift_d = '0;
              phase_d      = PH_ADDR;
            end
          end
        endcase
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detected_q   <= 1'b0;
      phase_q      <= PH_IDLE;
      byte_cnt_q   <= '0;
      words_left_q <= '0;
      write_mode_q <= 1'b0;
      cur_addr_q   <= '0;
      word_shift_q <= '0;
    end else begin
      detected_q   <= detected_d;
      phase_q      <= phase_d;
      byte_cnt_q   <= byte_cnt_d;
      words_left_q <= words_left_d;
      write_mode_q <= write_mode_d;
      cur_addr_q   <= cur_addr_d;
      word_shift_q <= word_shift_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a packet never starts before the baud byte
  a_phase_needs_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> detected_q)
    else $error("parser left idle before detection");

  // the data phase always has a word outstanding
  a_data_has_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (words_left_q != '0))
    else $error("data phase with no words left");

  // bursts carry between one and sixty-four requests
  a_burst_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.kind == KIND_BUS_READ) |->
      (job_o.count != '0 && job_o.count <= CountW'(64)))
    else $error("read burst count out of range");
`endif

endmodule

`default_nettype wire

// ===== src/ubb_fifo.sv =====
// ubb_fifo: short job queue between parser and executor
// depends on ubb_pkg
`default_nettype none

module ubb_fifo
  import ubb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("job queue underflow");

  // fill count grows on a push without a pop
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("fill count did not grow on push");
`endif

endmodule

`default_nettype wire

// ===== src/ubb_back.sv =====
// ubb_back: job executor, expands jobs into result beats, one per ready cycle
// depends on ubb_pkg
`default_nettype none

module ubb_back
  import ubb_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = DefAddrW
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  wire job_t  job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_item_o
);

  logic                  busy_q;
  kind_e                 kind_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [DataW-1:0]      data_q;
  logic                  last_q;
  logic [CountW-1:0]     rem_q;

  logic                  on_last;
  logic                  load;

  assign on_last = (rem_q == CountW'(1));
  assign load    = job_valid_i && (!busy_q || (out_ready_i && on_last));
  assign pop_o   = load;

  // result beat straight from the job registers
  assign out_valid_o             = busy_q;
  assign out_item_o.kind         = kind_q;
  assign out_item_o.bus_address  = DataW'(addr_q);
  assign out_item_o.word_data    = data_q;
  assign out_item_o.last_of_run  = on_last && last_q;

  // control: busy flag and remaining count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      rem_q  <= job_i.count;
    end else if (busy_q && out_ready_i) begin
      if (on_last) begin
        busy_q <= 1'b0;
      end
      rem_q <= rem_q - CountW'(1);
    end
  end

  // job payload and address stepping
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= job_i.kind;
      addr_q <= job_i.addr[ADDR_WIDTH-1:0];
      data_q <= job_i.data;
      last_q <= job_i.last;
    end else if (busy_q && out_ready_i) begin
      addr_q <= addr_q + ADDR_WIDTH'(AddrStep);
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0))
    else $error("executor busy with nothing left");

  // burst addresses step by one word
  a_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_ready_i && !on_last) |=>
      (addr_q == $past(addr_q) + ADDR_WIDTH'(AddrStep)))
    else $error("burst address did not step");

  // going idle only after the final beat of a job
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(on_last && out_ready_i))
    else $error("executor dropped a job early");
`endif

endmodule

`default_nettype wire

// ===== src/uart_debug_bus_bridge.sv =====
// uart_debug_bus_bridge: top level, parser front, job queue and executor back
// depends on ubb_pkg, ubb_front, ubb_fifo, ubb_back
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------
//   in      | input     | in_valid_i / in_ready_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i | out_item_o (out_item_t)
//
// one input beat per cycle while the two-entry job queue has room.
// a result beat per cycle while out_ready_i is high; an n-word read burst
// holds the executor n beats, so the queue fills and input stalls behind it.
// results leave from executor registers; a job is held in queue storage first.
// reset clears the parser, queue and executor; no clearing pass.
`default_nettype none

module uart_debug_bus_bridge
  import ubb_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = DefAddrW
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);

  logic push;
  logic full;
  logic pop;
  logic job_valid;
  job_t job_in;
  job_t job_out;

  ubb_front #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  ubb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  ubb_back #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_uart_debug_bus_bridge.sv =====
// tb_uart_debug_bus_bridge: self-checking testbench for the uart debug bus bridge
// depends on ubb_pkg and the uart_debug_bus_bridge top level; scoreboard holds
// predicted result beats that are compared against the output channel
`timescale 1ns / 100ps

module tb_uart_debug_bus_bridge;
  import ubb_pkg::*;

  localparam int unsigned AddrW         = 32;
  localparam logic [31:0] AddrMask      = 32'((64'd1 << AddrW) - 64'd1);
  localparam int          ClkHalf       = 6;
  localparam int          TimeoutCycles = 1_500_000;
  localparam int          HoldCycles    = 300;
  localparam int          MaxBurst      = 64;

  // clock, reset and channel drive, all known from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_item     = '0;
  logic      out_ready   = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // run controls and counters
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_req      = 1'b0;
  int        hold_left     = 0;
  int        items_sent    = 0;
  int        fail_count    = 0;
  int        beats_seen    = 0;
  int        kind_seen [4] = '{0, 0, 0, 0};

  // predicted results, oldest first
  out_item_t expected_beats [$];

  // shadow copy of the parser state
  bit              pr_detected;
  phase_e          pr_phase;
  logic [2:0]      pr_byte_cnt;
  logic [6:0]      pr_words_left;
  bit              pr_write;
  logic [31:0]     pr_cur_addr;
  logic [31:0]     pr_word_shift;

  uart_debug_bus_bridge #(
    .ADDR_WIDTH(AddrW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  // clock generation
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // queue one predicted result beat
  task automatic push_beat(input kind_e kind, input logic [31:0] addr,
                           input logic [31:0] data, input logic last);
    out_item_t r;
    r.kind        = kind;
    r.bus_address = addr;
    r.word_data   = data;
    r.last_of_run = last;
    expected_beats.push_back(r);
  endtask

  // parser prediction for one accepted input beat
  task automatic predict_bridge(input in_item_t it);
    logic [7:0] b;
    int         n;
    b = it.host_byte;
    n = 0;
    // read responses pass straight to the host, state untouched
    if (it.func == FUNC_READ_RESP) begin
      push_beat(KIND_HOST_WORD, '0, it.read_word, 1'b1);
      return;
    end
    // wait for the baud pattern
    if (!pr_detected) begin
      if (b == BaudByte) pr_detected = 1'b1;
      return;
    end
    case (pr_phase)
      PH_ADDR: begin
        // only the low four address bytes count
        if (pr_byte_cnt < UsedAddrBytes)
          pr_cur_addr |= {24'd0, b} << (8 * pr_byte_cnt);
        if (pr_byte_cnt < LastAddrByte) begin
          pr_byte_cnt++;
        end else begin
          pr_cur_addr &= AddrMask;
          pr_byte_cnt = '0;
          if (pr_write) begin
            pr_word_shift = '0;
            pr_phase      = PH_DATA;
          end else begin
            // whole read burst at once, address wraps
            while (pr_words_left > 0 && n < MaxBurst) begin
              push_beat(KIND_BUS_READ, pr_cur_addr, '0, pr_words_left == 7'd1);
              n++;
              pr_cur_addr = (pr_cur_addr + AddrStep) & AddrMask;
              pr_words_left--;
            end
            pr_words_left = '0;
            pr_phase      = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        pr_word_shift |= {24'd0, b} << (8 * pr_byte_cnt[1:0]);
        if (pr_byte_cnt < LastDataByte) begin
          pr_byte_cnt++;
        end else begin
          push_beat(KIND_BUS_WRITE, pr_cur_addr, pr_word_shift, pr_words_left <= 7'd1);
          pr_cur_addr   = (pr_cur_addr + AddrStep) & AddrMask;
          pr_byte_cnt   = '0;
          pr_word_shift = '0;
          if (pr_words_left > 0) pr_words_left--;
          if (pr_words_left == 0) pr_phase = PH_IDLE;
        end
      end
      default: begin
        // command byte; bit7 clear is a format error
        pr_phase = PH_IDLE;
        if (!b[CmdBit]) begin
          push_beat(KIND_FMT_ERROR, '0, '0, 1'b1);
        end else begin
          pr_write      = b[WriteBit];
          pr_words_left = {1'b0, b[5:0] & LenMask} + 7'd1;
          pr_byte_cnt   = '0;
          pr_cur_addr   = '0;
          pr_word_shift = '0;
          pr_phase      = PH_ADDR;
        end
      end
    endcase
  endtask

  // offer one input beat, with random idle cycles ahead of it
  task automatic send_item(input in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    predict_bridge(item);
  endtask

  task automatic send_host(input logic [7:0] b);
    in_item_t it;
    it           = '0;
    it.func      = FUNC_HOST_BYTE;
    it.host_byte = b;
    it.read_word = $urandom;
    send_item(it);
  endtask

  task automatic send_resp(input logic [31:0] w);
    in_item_t it;
    it           = '0;
    it.func      = FUNC_READ_RESP;
    it.host_byte = 8'($urandom_range(255));
    it.read_word = w;
    send_item(it);
  endtask

  // one packet; cut stops it after that many bytes (negative for whole packet)
  task automatic send_packet(input bit wr, input int len, input logic [31:0] addr,
                             input int cut);
    int         total;
    logic [7:0] b;
    total = 9 + (wr ? 4 * len : 0);
    for (int i = 0; i < total; i++) begin
      if (i == cut) break;
      if (i == 0) b = {1'b1, wr, 6'(len - 1)};
      else if (i <= 4) b = addr[8 * (i - 1) +: 8];
      else b = 8'($urandom_range(255));
      // occasional read response in the middle of a packet
      if (i > 0 && $urandom_range(19) == 0) send_resp($urandom);
      send_host(b);
    end
  endtask

  // receiver ready, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result beat against the oldest prediction
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      beats_seen++;
      kind_seen[out_item_o.kind]++;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d addr %h data %h last %0b",
               out_item_o.kind, out_item_o.bus_address, out_item_o.word_data,
               out_item_o.last_of_run);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_item_o.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_item_o.kind);
          fail_count++;
        end
        if (out_item_o.bus_address !== want.bus_address) begin
          $error("bus_address: expected %h, actual %h", want.bus_address,
                 out_item_o.bus_address);
          fail_count++;
        end
        if (out_item_o.word_data !== want.word_data) begin
          $error("word_data: expected %h, actual %h", want.word_data, out_item_o.word_data);
          fail_count++;
        end
        if (out_item_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                 out_item_o.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // detection, format errors, upper address bytes, wrap, mid-packet responses
  task automatic test_directed();
    send_resp(32'hFFFF_FFFF);
    send_host(8'h00);
    send_host(8'hFF);
    send_host(BaudByte);
    send_host(8'h7F);
    // single-word write, upper address bytes ignored
    send_host(8'hC0);
    send_host(8'hFF);
    send_host(8'hFF);
    send_resp(32'h0000_0000);
    send_host(8'hFF);
    send_host(8'hFF);
    send_host(8'hA5);
    send_host(8'h5A);
    send_host(8'h00);
    send_host(8'hFF);
    send_host(8'h00);
    send_host(8'hFF);
    send_host(8'h12);
    send_host(8'h34);
    // two-word read at the top of the address space
    send_host(8'h81);
    send_host(8'hFC);
    send_host(8'hFF);
    send_host(8'hFF);
    send_host(8'hFF);
    send_host(8'h00);
    send_host(8'h00);
    send_host(8'h00);
    send_host(8'h00);
  endtask

  // mostly well-formed packets, some noise and truncated packets
  task automatic test_random(input int n_items);
    int          start;
    int          pick;
    int          len;
    bit          wr;
    logic [31:0] addr;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      wr   = 1'($urandom_range(1));
      if (wr) len = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 3);
      else len = ($urandom_range(5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      addr = ($urandom_range(7) == 0) ? (32'hFFFF_FFF0 | $urandom_range(15)) : $urandom;
      if (pick < 70) send_packet(wr, len, addr, -1);
      else if (pick < 80) send_resp($urandom);
      else if (pick < 88) send_host(8'($urandom_range(127)));
      else send_packet(wr, len, addr, $urandom_range(1, 8 + (wr ? 4 * len : 0)));
    end
  endtask

  // receiver stalls for a long stretch behind full read bursts
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 4; k++) begin
      send_packet(1'b0, MaxBurst, $urandom, -1);
      send_resp($urandom);
    end
  endtask

  // main sequence
  initial begin
    pr_detected   = 1'b0;
    pr_phase      = PH_IDLE;
    pr_byte_cnt   = '0;
    pr_words_left = '0;
    pr_write      = 1'b0;
    pr_cur_addr   = '0;
    pr_word_shift = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 32;
    recv_idle_pct = 76;
    test_directed();
    test_random(120);

    send_idle_pct = 0;
    test_backpressure();

    send_idle_pct = 76;
    recv_idle_pct = 32;
    test_random(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(120);

    // drain and let the block settle
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (MaxBurst + 16) @(posedge clk_i);

    $display("run covered %0d input beats and %0d result beats", items_sent, beats_seen);
    $display("writes %0d, reads %0d, host words %0d, format errors %0d",
             kind_seen[KIND_BUS_WRITE], kind_seen[KIND_BUS_READ],
             kind_seen[KIND_HOST_WORD], kind_seen[KIND_FMT_ERROR]);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== uart_debug_bus_bridge.f =====
src/ubb_pkg.sv
src/ubb_front.sv
src/ubb_fifo.sv
src/ubb_back.sv
src/uart_debug_bus_bridge.sv
dv/tb_uart_debug_bus_bridge.sv
